### rtl/core/bbffa_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared constants, default parameters and result codes for the first-fit
// bitmap block allocator.
// ----------------------------------------------------------------------------
package bbffa_pkg;

	localparam int NUM_BLOCKS_DEF      = 256;
	localparam int BYTES_PER_BLOCK_DEF = 16;

	localparam int ADDR_W   = 32;
	localparam int BYTES_W  = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 9;

	localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'h2000_1000;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE       = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NULL       = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 3'd5;

endpackage

### rtl/core/block_bitmap_first_fit_allocator_core.sv
// Allocate runs a bit-serial map scan through the single RAM read port,
// followed by marking the found run. Free runs an index walk with one adder,
// then clears one map bit per cycle. One request is in work at a time.
// After reset the map RAM is swept clear, with no request accepted meanwhile;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// First-fit bitmap block allocator
// Keeps a used/free bit per heap block, serves allocate and free requests and
// returns one result per request.
// ----------------------------------------------------------------------------
module block_bitmap_first_fit_allocator_core #(
	parameter int NUM_BLOCKS      = bbffa_pkg::NUM_BLOCKS_DEF,
	parameter int BYTES_PER_BLOCK = bbffa_pkg::BYTES_PER_BLOCK_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bbffa_pkg::ADDR_W-1:0]      heap_base_address,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [bbffa_pkg::BYTES_W-1:0]     request_bytes,
	input  logic [bbffa_pkg::ADDR_W-1:0]      target_address,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bbffa_pkg::STATUS_W-1:0]    status,
	output logic [bbffa_pkg::ADDR_W-1:0]      granted_address,
	output logic [bbffa_pkg::COUNT_W-1:0]     blocks_changed
);

	import bbffa_pkg::*;

	localparam int    IW         = $clog2(NUM_BLOCKS);
	localparam int    CW         = IW + 1;
	localparam longint HEAP_BYTES = longint'(NUM_BLOCKS) * longint'(BYTES_PER_BLOCK);
	localparam int    OFF_W      = $clog2(HEAP_BYTES + BYTES_PER_BLOCK) + 1;
	localparam int    RBW        = BYTES_W + 1;

	localparam logic [CW-1:0]     NB_C      = CW'(NUM_BLOCKS);
	localparam logic [IW-1:0]     LAST_IDX  = IW'(NUM_BLOCKS - 1);
	localparam logic [ADDR_W:0]   HEAP_C    = (ADDR_W+1)'(HEAP_BYTES);
	localparam logic [OFF_W-1:0]  BPB_OFF   = OFF_W'(BYTES_PER_BLOCK);
	localparam logic [RBW-1:0]    BPB_RB    = RBW'(BYTES_PER_BLOCK);
	localparam logic [ADDR_W-1:0] BPB_ADDR  = ADDR_W'(BYTES_PER_BLOCK);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_WALK  = 8'b0000_1000,
		ST_SCAN  = 8'b0001_0000,
		ST_MARK  = 8'b0010_0000,
		ST_FREE  = 8'b0100_0000,
		ST_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic                func_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   base_q;
	logic [OFF_W-1:0]    offset_q;
	logic [OFF_W-1:0]    acc_q;
	logic [CW-1:0]       ridx_q;
	logic                ev_s1;
	logic [IW-1:0]       eidx_s1;
	logic [IW-1:0]       span_head_q;
	logic [CW-1:0]       run_len_q;
	logic [RBW-1:0]      run_bytes_q;
	logic [IW-1:0]       mark_q;
	logic [CW-1:0]       cnt_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   res_grant_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ADDR_W-1:0]   out_grant_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic                wr_data;
	logic [IW-1:0]       rd_addr;
	logic                rd_data;

	logic                issue;
	logic [ADDR_W-1:0]   diff;
	logic [IW-1:0]       new_start;
	logic [CW-1:0]       new_len;
	logic [RBW-1:0]      new_bytes;
	logic                fits;

	bbffa_ram #(
		.WIDTH(1),
		.DEPTH(NUM_BLOCKS)
	) u_map (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign granted_address = out_grant_q;
	assign blocks_changed  = out_count_q;

	assign rd_addr   = ridx_q[IW-1:0];
	assign issue     = (ridx_q < NB_C);
	assign diff      = addr_q - base_q;
	assign new_start = (run_len_q == '0) ? eidx_s1 : span_head_q;
	assign new_len   = run_len_q + CW'(1);
	assign new_bytes = run_bytes_q + BPB_RB;
	assign fits      = (new_bytes >= {1'b0, bytes_q});

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = eidx_s1;
		wr_data = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = ridx_q[IW-1:0];
			end
			ST_FREE: begin
				wr_en   = ev_s1 && rd_data;
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_addr = mark_q;
				wr_data = 1'b1;
			end
			default: begin
				wr_en   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= HEAP_BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= heap_base_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ridx_q      <= '0;
			ev_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					ridx_q <= ridx_q + CW'(1);
					if (ridx_q[IW-1:0] == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						bytes_q <= request_bytes;
						addr_q  <= target_address;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					res_grant_q <= '0;
					cnt_q       <= '0;
					ridx_q      <= '0;
					ev_s1       <= 1'b0;
					acc_q       <= '0;
					run_len_q   <= '0;
					run_bytes_q <= '0;
					offset_q    <= OFF_W'(diff);
					res_status_q <= STATUS_DONE;
					if (func_q == FUNC_ALLOC) begin
						if (bytes_q == '0) begin
							res_status_q <= STATUS_ZERO_SIZE;
							state_q      <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end else if (addr_q == '0) begin
						res_status_q <= STATUS_NULL;
						state_q      <= ST_RESP;
					end else if ((addr_q < base_q) || ({1'b0, diff} >= HEAP_C)) begin
						res_status_q <= STATUS_OUTSIDE;
						state_q      <= ST_RESP;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (acc_q == offset_q) begin
						state_q <= ST_FREE;
					end else if (acc_q > offset_q) begin
						res_status_q <= STATUS_MISALIGNED;
						state_q      <= ST_RESP;
					end else begin
						acc_q  <= acc_q + BPB_OFF;
						ridx_q <= ridx_q + CW'(1);
					end
				end
				ST_SCAN: begin
					ev_s1   <= issue;
					eidx_s1 <= ridx_q[IW-1:0];
					if (issue) begin
						ridx_q <= ridx_q + CW'(1);
					end
					if (ev_s1) begin
						if (!rd_data) begin
							span_head_q <= new_start;
							run_len_q   <= new_len;
							run_bytes_q <= new_bytes;
						end else begin
							run_len_q   <= '0;
							run_bytes_q <= '0;
						end
						if (!rd_data && fits) begin
							mark_q      <= new_start;
							cnt_q       <= new_len;
							res_grant_q <= base_q + (ADDR_W'(new_start) * BPB_ADDR);
							ev_s1       <= 1'b0;
							state_q     <= ST_MARK;
						end else if (eidx_s1 == LAST_IDX) begin
							res_status_q <= STATUS_NO_FIT;
							ev_s1        <= 1'b0;
							state_q      <= ST_RESP;
						end
					end
				end
				ST_MARK: begin
					mark_q    <= mark_q + IW'(1);
					run_len_q <= run_len_q - CW'(1);
					if (run_len_q == CW'(1)) begin
						state_q <= ST_RESP;
					end
				end
				ST_FREE: begin
					ev_s1   <= issue;
					eidx_s1 <= ridx_q[IW-1:0];
					if (issue) begin
						ridx_q <= ridx_q + CW'(1);
					end
					if (ev_s1) begin
						if (rd_data) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (!rd_data || (eidx_s1 == LAST_IDX)) begin
							ev_s1   <= 1'b0;
							state_q <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_grant_q  <= res_grant_q;
						out_count_q  <= COUNT_W'(cnt_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CHECK))
		else $error("Accepted request did not enter the check step.");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !wr_en)
		else $error("Map written during the allocation scan.");

	a_mark_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (run_len_q != '0))
		else $error("Marking with an empty run.");

	a_free_ports_apart: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FREE) && wr_en) |-> (wr_addr != rd_addr))
		else $error("Free pass reads and writes the same map entry.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STATUS_DONE)) |->
		((granted_address == '0) && (blocks_changed == '0)))
		else $error("Failed request reports an address or a block count.");

endmodule

### rtl/core/bbffa_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbffa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
